### sv/sha1_stream_hasher_macros.svh
// Assertion macros for the SHA-1 stream hasher checker.
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHA1SH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha1 stream hasher check failed");

// Next-cycle implication, disabled during reset.
`define SHA1SH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha1 stream hasher check failed");

`endif

### sv/sha1sh_pkg.sv
// Package: types and constants shared by the SHA-1 stream hasher modules.
`default_nettype none

package sha1sh_pkg;

   typedef logic [31:0] word_type;

   localparam int LENGTH_BITS_DEF = 64;
   localparam int BYTE_OFFSET_W   = 6;
   localparam int ROUND_W         = 7;
   localparam int WORD_INDEX_W    = 3;

   localparam logic [BYTE_OFFSET_W-1:0] OFFSET_LAST = 6'd63;
   localparam logic [BYTE_OFFSET_W-1:0] LEN_START   = 6'd56;
   localparam logic [ROUND_W-1:0]       ROUND_LAST  = 7'd79;
   localparam logic [WORD_INDEX_W-1:0]  LAST_WORD_INDEX = 3'd4;
   localparam logic [7:0]               PAD_BYTE    = 8'h80;

   localparam word_type K_R0 = 32'h5A827999;
   localparam word_type K_R1 = 32'h6ED9EBA1;
   localparam word_type K_R2 = 32'h8F1BBCDC;
   localparam word_type K_R3 = 32'hCA62C1D6;

   localparam word_type [4:0] H_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMP,
      ST_PAD,
      ST_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_FOLD
   } core_state_type;

   typedef struct packed {
      logic       load_byte;
      logic       new_word;
      logic [7:0] byte_data;
      logic       start;
      logic       chain_init;
   } core_ctrl_type;

   typedef struct packed {
      logic busy;
   } core_stat_type;

endpackage

`default_nettype wire

### sv/sha1sh_core.sv
// Compression core: byte packer, message schedule window and one shared round unit.
`default_nettype none

module sha1sh_core (
   input  logic                          clock,
   input  logic                          reset,
   input  sha1sh_pkg::core_ctrl_type     ctrl,
   output sha1sh_pkg::core_stat_type     stat,
   output sha1sh_pkg::word_type [4:0]    chain_value
);
   import sha1sh_pkg::*;

   core_state_type       state_ff, state_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   word_type [4:0]       work_ff, work_in;
   word_type [4:0]       chain_ff, chain_in;
   word_type [15:0]      sched_ff, sched_in;
   word_type             f_val, k_val, w_mix, w_next, t_sum;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      work_in  = work_ff;
      chain_in = chain_ff;
      sched_in = sched_ff;

      if (round_ff inside {[7'd0:7'd19]}) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = K_R0;
      end else if (round_ff inside {[7'd20:7'd39]}) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K_R1;
      end else if (round_ff inside {[7'd40:7'd59]}) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                 (work_ff[2] & work_ff[3]);
         k_val = K_R2;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K_R3;
      end

      t_sum  = {work_ff[0][26:0], work_ff[0][31:27]} + f_val + work_ff[4] + k_val
               + sched_ff[0];
      w_mix  = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      w_next = {w_mix[30:0], w_mix[31]};

      if (ctrl.load_byte) begin
         if (ctrl.new_word) begin
            for (int j = 0; j < 15; j++) begin
               sched_in[j] = sched_ff[j+1];
            end
            sched_in[15] = {24'd0, ctrl.byte_data};
         end else begin
            sched_in[15] = {sched_ff[15][23:0], ctrl.byte_data};
         end
      end

      case (state_ff)
         CORE_IDLE: begin
            if (ctrl.start) begin
               work_in  = chain_ff;
               round_in = '0;
               state_in = CORE_ROUND;
            end
         end
         CORE_ROUND: begin
            work_in[0] = t_sum;
            work_in[1] = work_ff[0];
            work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            for (int j = 0; j < 15; j++) begin
               sched_in[j] = sched_ff[j+1];
            end
            sched_in[15] = w_next;
            round_in     = round_ff + 7'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = CORE_FOLD;
            end
         end
         CORE_FOLD: begin
            for (int j = 0; j < 5; j++) begin
               chain_in[j] = chain_ff[j] + work_ff[j];
            end
            state_in = CORE_IDLE;
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase

      if (ctrl.chain_init) begin
         chain_in = H_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         round_ff <= '0;
         chain_ff <= H_INIT;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   assign stat.busy   = (state_ff != CORE_IDLE);
   assign chain_value = chain_ff;

endmodule

`default_nettype wire

### sv/sha1_stream_hasher.sv
// SHA-1 stream hasher top level: byte intake, padding sequencer and digest output.
//
// Usage:
//   Input channel (req_*): one transfer per message byte. req_byte_valid says
//   whether req_data_byte is part of the message; req_is_last ends the message
//   (with req_byte_valid low it closes the message without adding a byte, so an
//   empty message hashes too). A transfer with neither flag set does nothing.
//   Output channel (rsp_*): five transfers per message, digest word 0 first,
//   rsp_last_word set on word 4.
// Timing:
//   The 64th byte of a block starts the round unit, which runs one SHA-1
//   round per cycle; req_stall is high while it runs.
//   After the final transfer the padding bytes are inserted one per cycle,
//   pausing while a filled block is compressed, up to 72 when the length
//   spills into a second block; each filled block is compressed before
//   the digest goes out.
//   The input stays stalled until the fifth word has transferred.
// Reset: chaining values return to the initial constants, the bit count to
//   zero; the block is ready as soon as reset falls.
// Receiver stall: the current digest word holds until it transfers; the
//   block takes no new input meanwhile.
`default_nettype none

module sha1_stream_hasher #(
   parameter int LENGTH_BITS = sha1sh_pkg::LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1sh_pkg::*;

   top_state_type              state_ff, state_in;
   top_state_type              ret_ff, ret_in;
   logic [BYTE_OFFSET_W-1:0]   offset_ff, offset_in;
   logic [LENGTH_BITS-1:0]     bits_ff, bits_in, bits_next;
   logic [63:0]                len_ff, len_in;
   logic                       pad_first_ff, pad_first_in;
   logic                       len_ok_ff, len_ok_in;
   logic [WORD_INDEX_W-1:0]    idx_ff, idx_in;
   logic                       req_fire, rsp_fire, len_byte;
   logic [7:0]                 pad_data;
   core_ctrl_type              ctrl;
   core_stat_type              stat;
   word_type [4:0]             chain_value;

   sha1sh_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .stat        (stat),
      .chain_value (chain_value)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_fire  = rsp_valid && !rsp_stall;

   assign rsp_digest_word = chain_value[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == LAST_WORD_INDEX);

   assign bits_next = bits_ff + (req_byte_valid ? LENGTH_BITS'(8) : LENGTH_BITS'(0));
   assign len_byte  = !pad_first_ff && len_ok_ff && (offset_ff >= LEN_START);

   always_comb begin
      if (pad_first_ff) begin
         pad_data = PAD_BYTE;
      end else if (len_byte) begin
         pad_data = len_ff[63:56];
      end else begin
         pad_data = 8'd0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      offset_in    = offset_ff;
      bits_in      = bits_ff;
      len_in       = len_ff;
      pad_first_in = pad_first_ff;
      len_ok_in    = len_ok_ff;
      idx_in       = idx_ff;
      ctrl         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               len_in       = 64'(bits_next);
               pad_first_in = 1'b1;
               len_ok_in    = 1'b0;
               if (req_byte_valid) begin
                  ctrl.load_byte = 1'b1;
                  ctrl.new_word  = (offset_ff[1:0] == 2'd0);
                  ctrl.byte_data = req_data_byte;
                  offset_in      = offset_ff + 6'd1;
                  bits_in        = bits_next;
               end
               if (req_byte_valid && offset_ff == OFFSET_LAST) begin
                  ctrl.start = 1'b1;
                  state_in   = ST_COMP;
                  ret_in     = req_is_last ? ST_PAD : ST_IDLE;
               end else if (req_is_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctrl.load_byte = 1'b1;
            ctrl.new_word  = (offset_ff[1:0] == 2'd0);
            ctrl.byte_data = pad_data;
            offset_in      = offset_ff + 6'd1;
            pad_first_in   = 1'b0;
            if (len_byte) begin
               len_in = {len_ff[55:0], 8'd0};
            end
            if (pad_first_ff && offset_ff < LEN_START) begin
               len_ok_in = 1'b1;
            end
            if (offset_ff == OFFSET_LAST) begin
               ctrl.start = 1'b1;
               state_in   = ST_COMP;
               ret_in     = len_ok_ff ? ST_OUT : ST_PAD;
               len_ok_in  = 1'b1;
            end
         end
         ST_COMP: begin
            if (!stat.busy) begin
               state_in = ret_ff;
               idx_in   = '0;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (idx_ff == LAST_WORD_INDEX) begin
                  ctrl.chain_init = 1'b1;
                  bits_in         = '0;
                  state_in        = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         offset_ff    <= '0;
         bits_ff      <= '0;
         pad_first_ff <= 1'b0;
         len_ok_ff    <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         offset_ff    <= offset_in;
         bits_ff      <= bits_in;
         pad_first_ff <= pad_first_in;
         len_ok_ff    <= len_ok_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

endmodule

`default_nettype wire

### sv/sha1sh_check.sv
// Port-level checker for the SHA-1 stream hasher, bound to the top level.
`default_nettype none

`include "sha1_stream_hasher_macros.svh"

module sha1sh_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_byte_valid,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // Stalled digest word holds.
   `SHA1SH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index))

   // No input transfer while the digest is being delivered.
   `SHA1SH_ASSERT_NOW(a_no_intake, clock, reset, rsp_valid, req_stall)

   // Digest words go out back to back in order.
   `SHA1SH_ASSERT_NEXT(a_word_order, clock, reset, rsp_valid && !rsp_stall && !rsp_last_word, rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)

   // Last flag marks word four and nothing else.
   `SHA1SH_ASSERT_NOW(a_last_flag, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == 3'd4) && rsp_word_index <= 3'd4)

endmodule

bind sha1_stream_hasher sha1sh_check u_check (.*);

`default_nettype wire

### tb/sv/tb_sha1_stream_hasher.sv
// Testbench for sha1_stream_hasher: random byte messages checked against a SHA-1 predictor.
`timescale 1ns / 100ps

module tb_sha1_stream_hasher;
   import sha1sh_pkg::*;

   localparam int RANDOM_ITEMS = 460;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 300;

   class sha1_scoreboard;
      typedef struct {
         word_type   word;
         logic [2:0] index;
         logic       last;
      } digest_entry_type;

      word_type         chain[5];
      logic [7:0]       block_bytes[64];
      logic [63:0]      bit_count;
      digest_entry_type digest_queue[$];
      int               errors;
      int               words_checked;
      int               messages;
      int               two_block_pads;
      int               bytes_hashed;

      function new();
         errors = 0;
         words_checked = 0;
         messages = 0;
         two_block_pads = 0;
         bytes_hashed = 0;
         foreach (block_bytes[i]) block_bytes[i] = 8'h00;
         start_message();
      endfunction

      function void start_message();
         for (int i = 0; i < 5; i++) chain[i] = H_INIT[i];
         bit_count = 64'd0;
      endfunction

      function void compress_block();
         word_type sched[80];
         word_type a, b, c, d, e, f, k, t;
         for (int i = 0; i < 16; i++) begin
            sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
         end
         for (int i = 16; i < 80; i++) begin
            t = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
            sched[i] = {t[30:0], t[31]};
         end
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
               f = (b & c) | (~b & d);
               k = K_R0;
            end else if (i < 40) begin
               f = b ^ c ^ d;
               k = K_R1;
            end else if (i < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = K_R2;
            end else begin
               f = b ^ c ^ d;
               k = K_R3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + sched[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      // One accepted input transfer; a final transfer queues the five digest words.
      function void note_input(logic [7:0] data, logic has_byte, logic last);
         logic [5:0] offset;
         if (has_byte) begin
            offset = bit_count[8:3];
            block_bytes[offset] = data;
            bit_count += 64'd8;
            bytes_hashed++;
            if (offset == OFFSET_LAST) compress_block();
         end
         if (!last) return;
         offset = bit_count[8:3];
         block_bytes[offset] = PAD_BYTE;
         for (int i = offset + 1; i < 64; i++) block_bytes[i] = 8'h00;
         if (offset >= LEN_START) begin
            compress_block();
            for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
            two_block_pads++;
         end
         for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_count[63 - 8*i -: 8];
         compress_block();
         for (int i = 0; i < 5; i++) begin
            digest_queue.push_back('{chain[i], 3'(i), 3'(i) == LAST_WORD_INDEX});
         end
         messages++;
         start_message();
      endfunction

      function void check_result(word_type word, logic [2:0] index, logic last);
         digest_entry_type want;
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest word %h index %0d last %0b",
                     $time, word, index, last);
            errors++;
            return;
         end
         want = digest_queue.pop_front();
         words_checked++;
         if (word !== want.word) begin
            $display("%0t: digest_word mismatch: expected %h, actual %h",
                     $time, want.word, word);
            errors++;
         end
         if (index !== want.index) begin
            $display("%0t: word_index mismatch: expected %0d, actual %0d",
                     $time, want.index, index);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_word mismatch: expected %0b, actual %0b",
                     $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha1_scoreboard sb;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_armed = 1'b0;
   int holds_done = 0;
   int items_sent = 0;
   int idle_items = 0;
   int quiet_cycles = 0;

   sha1_stream_hasher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_byte_valid  (req_byte_valid),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_digest_word, rsp_word_index, rsp_last_word);
         end
         if (req_valid && !req_stall) begin
            sb.note_input(req_data_byte, req_byte_valid, req_is_last);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("sha1_stream_hasher test failed");
      $finish;
   end

   // Receiver: random stall, plus one long hold once armed and a word is waiting.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_armed && rsp_valid) begin
            hold_armed = 1'b0;
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   task automatic send_item(input logic [7:0] data, input logic has_byte, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_data_byte  <= data;
      req_byte_valid <= has_byte;
      req_is_last    <= last;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (has_byte || last) items_sent++;
      else idle_items++;
   endtask

   initial begin
      int boundary_lengths[];
      int base;
      int done;
      int len;
      int pick;
      int msg_index;
      bit use_marker;

      boundary_lengths = '{55, 56, 63, 64, 119, 120, 0, 1};
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty message, "abc", idle transfers inside and between messages, byte extremes
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h5A, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);

      // long output hold while the sender keeps offering the next message
      hold_armed = 1'b1;

      base = items_sent;
      msg_index = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         done = items_sent - base;
         if (done < RANDOM_ITEMS / 3) begin
            send_idle_pct = 25;
            rsp_idle_pct  = 67;
         end else if (done < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 67;
            rsp_idle_pct  = 25;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         if (msg_index < boundary_lengths.size()) begin
            len = boundary_lengths[msg_index];
         end else begin
            pick = $urandom_range(99);
            if (pick < 45) len = $urandom_range(12, 0);
            else if (pick < 75) len = $urandom_range(70, 50);
            else if (pick < 90) len = $urandom_range(49, 13);
            else len = $urandom_range(135, 110);
         end
         use_marker = ($urandom_range(1) == 1) || (len == 0);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !use_marker && (i == len - 1));
         end
         if (use_marker) send_item(8'($urandom), 1'b0, 1'b1);
         msg_index++;
      end
      req_valid <= 1'b0;

      while (sb.digest_queue.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Hashed %0d messages (%0d needing a second padding block), %0d bytes, %0d idle.",
               sb.messages, sb.two_block_pads, sb.bytes_hashed, idle_items);
      $display("Checked %0d digest words over three stall mixes and %0d long output hold.",
               sb.words_checked, holds_done);
      if (sb.errors == 0) begin
         $display("sha1_stream_hasher test passed");
      end else begin
         $display("sha1_stream_hasher test failed");
      end
      $finish;
   end

endmodule

### sha1_stream_hasher.f
+incdir+sv
sv/sha1sh_pkg.sv
sv/sha1sh_core.sv
sv/sha1_stream_hasher.sv
sv/sha1sh_check.sv
tb/sv/tb_sha1_stream_hasher.sv
